@@ hw/rtl/spc_pkg.sv @@
// Shared constants and types for the sprite pixel compositor.
package spc_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_BLEND_MODE  = 2'd0;
   localparam logic [1:0] CSR_KEY_COLOR   = 2'd1;
   localparam logic [1:0] CSR_FADE_FACTOR = 2'd2;

   // Blend mode codes; the remaining codes behave as opaque copy.
   localparam logic [2:0] MODE_OPAQUE  = 3'd0;
   localparam logic [2:0] MODE_MASK    = 3'd1;
   localparam logic [2:0] MODE_PREMUL  = 3'd2;
   localparam logic [2:0] MODE_KEY     = 3'd3;
   localparam logic [2:0] MODE_FADED   = 3'd4;

   localparam logic [8:0]  FADE_ONE     = 9'd256;
   localparam logic [7:0]  CHAN_MAX     = 8'd255;
   localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;

   // Blue, green, red and alpha lanes, in that order from the lowest bits.
   localparam int LANES = 4;

   // Per-pixel operation decided at the input stage.
   typedef enum logic [2:0] {
      OP_COPY,
      OP_KEYSKIP,
      OP_PASS_SRC,
      OP_PASS_DEST,
      OP_MIX,
      OP_PREMUL
   } op_type;

endpackage

@@ hw/rtl/sprite_pixel_compositor_core.sv @@
// Four-stage pipelined ARGB8888 sprite compositor with a plain register write port.

// The compositor takes one pixel triple per transfer (destination, sprite and mask, all
// ARGB8888 with alpha in the top byte) and returns one result per transfer: the pixel to
// store and a write enable that is low only when colour keying rejects the sprite pixel.
// It sustains one pixel per clock while the output side is not stalled; a pixel's result
// passes through the four register stages: mode decode and fade scaling, the per-lane
// multiply-accumulate, the division by 255 estimate and its one-step correction with
// saturation and final selection. Every stage has its own valid bit and takes new data
// whenever it is empty or its successor moves, so a stall on the result side fills
// bubbles before it blocks the input side, and no pixel is lost or repeated. The blend
// mode, key colour and fade factor are read live by the stages and must only be written
// while no pixel is in flight.
module sprite_pixel_compositor_core
   import spc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // dest_pixel [31:0], src_pixel [63:32], mask_pixel [95:64]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_pixel [31:0]
   output logic        rsp_tuser,   // write_enable [0]
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Configuration registers. A write to the unused index is simply dropped.
   // ---------------------------------------------------------------------------------
   logic [2:0]  mode_ff;
   logic [31:0] key_ff;
   logic [8:0]  fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OPAQUE;
         key_ff  <= '0;
         fade_ff <= FADE_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLEND_MODE:  mode_ff <= csr_wdata[2:0];
            CSR_KEY_COLOR:   key_ff  <= csr_wdata;
            CSR_FADE_FACTOR: fade_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Pipeline flow control. Each stage loads when it is empty or when the stage after
   // it hands its contents on, so bubbles are squeezed out during an output stall.
   // ---------------------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: decode the mode into a per-pixel operation, resolve the premultiplied
   // early-outs and the key match, and form the blend weight. In faded mode the weight
   // is the sprite alpha scaled by the saturated 1.8 fade factor.
   // ---------------------------------------------------------------------------------
   logic [31:0] in_dest, in_src, in_mask;
   logic [7:0]  in_sa, in_da;
   logic [8:0]  fade_sat;
   logic [16:0] fade_prod;
   op_type      op1_in;
   logic [7:0]  w1_in;

   assign in_dest   = req_tdata[31:0];
   assign in_src    = req_tdata[63:32];
   assign in_mask   = req_tdata[95:64];
   assign in_sa     = in_src[31:24];
   assign in_da     = in_dest[31:24];
   assign fade_sat  = (fade_ff > FADE_ONE) ? FADE_ONE : fade_ff;
   assign fade_prod = 17'(in_sa) * 17'(fade_sat);

   always_comb begin
      op1_in = OP_COPY;
      w1_in  = in_mask[23:16];
      unique case (mode_ff)
         MODE_MASK: op1_in = OP_MIX;
         MODE_FADED: begin
            op1_in = OP_MIX;
            // The product never exceeds 255 * 256, so bits above 15 are always clear.
            w1_in  = fade_prod[15:8];
         end
         MODE_PREMUL: begin
            priority if (in_da == 8'd0 || in_sa == CHAN_MAX) op1_in = OP_PASS_SRC;
            else if (in_sa == 8'd0)                          op1_in = OP_PASS_DEST;
            else                                             op1_in = OP_PREMUL;
         end
         MODE_KEY: op1_in = (in_src == key_ff) ? OP_KEYSKIP : OP_COPY;
         default: op1_in = OP_COPY;
      endcase
   end

   op_type      op1_ff;
   logic [31:0] d1_ff, s1_ff;
   logic [7:0]  w1_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op1_ff <= op1_in;
         d1_ff  <= in_dest;
         s1_ff  <= in_src;
         w1_ff  <= w1_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: one multiply-accumulate per lane. Mask and faded blends weight the
   // destination by 255-w and the sprite by w; premultiplied over weights the
   // destination by 255 minus sprite alpha and the sprite by 255. The alpha lane
   // divides destination alpha times its coefficient by 255 and later adds a base:
   // for the blends that coefficient is 255, which gives back destination alpha.
   // ---------------------------------------------------------------------------------
   logic [7:0]  coef_d, coef_s, coef_a, base_a;
   logic [16:0] num2_in [LANES];
   logic [15:0] prod_d  [LANES];
   logic [15:0] prod_s  [LANES];

   always_comb begin
      if (op1_ff == OP_PREMUL) begin
         coef_d = CHAN_MAX - s1_ff[31:24];
         coef_s = CHAN_MAX;
         coef_a = CHAN_MAX - s1_ff[31:24];
         base_a = s1_ff[31:24];
      end else begin
         coef_d = CHAN_MAX - w1_ff;
         coef_s = w1_ff;
         coef_a = CHAN_MAX;
         base_a = w1_ff;
      end
      for (int i = 0; i < LANES - 1; i++) begin
         prod_d[i] = 16'(d1_ff[8*i +: 8]) * 16'(coef_d);
         prod_s[i] = 16'(s1_ff[8*i +: 8]) * 16'(coef_s);
      end
      prod_d[LANES-1] = 16'(d1_ff[31:24]) * 16'(coef_a);
      prod_s[LANES-1] = '0;
      for (int i = 0; i < LANES; i++) begin
         num2_in[i] = 17'(prod_d[i]) + 17'(prod_s[i]);
      end
   end

   op_type      op2_ff;
   logic [31:0] d2_ff, s2_ff;
   logic [7:0]  base2_ff;
   logic [16:0] num2_ff [LANES];

   always_ff @(posedge clock) begin
      if (rdy2) begin
         op2_ff   <= op1_ff;
         d2_ff    <= d1_ff;
         s2_ff    <= s1_ff;
         base2_ff <= base_a;
         num2_ff  <= num2_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 3: estimate n/255 as (n + n/256)/256. For numerators up to 2 * 255 * 255
   // this is either exact or one short, and the remainder against 255 tells which.
   // ---------------------------------------------------------------------------------
   logic [17:0] est_sum [LANES];
   logic [8:0]  q3_in   [LANES];
   logic [16:0] q_x255  [LANES];
   logic [16:0] rem_all [LANES];
   logic [8:0]  r3_in   [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         est_sum[i] = 18'(num2_ff[i]) + 18'(num2_ff[i] >> 8);
         q3_in[i]   = est_sum[i][16:8];
         q_x255[i]  = {q3_in[i], 8'b0} - 17'(q3_in[i]);
         rem_all[i] = num2_ff[i] - q_x255[i];
         r3_in[i]   = rem_all[i][8:0];
      end
   end

   op_type      op3_ff;
   logic [31:0] d3_ff, s3_ff;
   logic [7:0]  base3_ff;
   logic [8:0]  q3_ff [LANES];
   logic [8:0]  r3_ff [LANES];

   always_ff @(posedge clock) begin
      if (rdy3) begin
         op3_ff   <= op2_ff;
         d3_ff    <= d2_ff;
         s3_ff    <= s2_ff;
         base3_ff <= base2_ff;
         q3_ff    <= q3_in;
         r3_ff    <= r3_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 4: apply the correction, saturate the lanes, add the alpha base and pick
   // the result for the operation. This is the output register.
   // ---------------------------------------------------------------------------------
   logic [9:0]  quot  [LANES];
   logic [9:0]  alpha_sum;
   logic [7:0]  lane8 [LANES];
   logic [31:0] arith_pixel;
   logic [31:0] pixel4_in;
   logic        we4_in;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         quot[i] = 10'(q3_ff[i]) + 10'(r3_ff[i] >= 9'(CHAN_MAX));
      end
      for (int i = 0; i < LANES - 1; i++) begin
         lane8[i] = (quot[i] > 10'(CHAN_MAX)) ? CHAN_MAX : quot[i][7:0];
      end
      alpha_sum        = 10'(base3_ff) + quot[LANES-1];
      lane8[LANES-1]   = (alpha_sum > 10'(CHAN_MAX)) ? CHAN_MAX : alpha_sum[7:0];
      arith_pixel      = {lane8[3], lane8[2], lane8[1], lane8[0]};

      we4_in = 1'b1;
      unique case (op3_ff)
         OP_COPY:      pixel4_in = s3_ff | OPAQUE_ALPHA;
         OP_KEYSKIP: begin
            pixel4_in = d3_ff;
            we4_in    = 1'b0;
         end
         OP_PASS_SRC:  pixel4_in = s3_ff;
         OP_PASS_DEST: pixel4_in = d3_ff;
         default:      pixel4_in = arith_pixel;
      endcase
   end

   op_type      op4_ff;
   logic [31:0] pixel4_ff;
   logic        we4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         op4_ff    <= op3_ff;
         pixel4_ff <= pixel4_in;
         we4_ff    <= we4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = pixel4_ff;
   assign rsp_tuser  = we4_ff;

   // ---------------------------------------------------------------------------------
   // Checks on the datapath and flow control.
   // ---------------------------------------------------------------------------------

   // Only a colour key match may suppress the write.
   a_we_only_on_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (op4_ff == OP_KEYSKIP))
      else $error("write enable dropped without a key match");

   // The multiply-accumulate never exceeds twice 255 squared.
   a_num_bound: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (num2_ff[0] <= 17'd130050 && num2_ff[1] <= 17'd130050 &&
                 num2_ff[2] <= 17'd130050 && num2_ff[3] <= 17'd130050))
      else $error("lane numerator out of range");

   // The quotient estimate is at most one short, so the remainder stays below 510.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (r3_ff[0] < 9'd510 && r3_ff[1] < 9'd510 &&
                 r3_ff[2] < 9'd510 && r3_ff[3] < 9'd510))
      else $error("division estimate off by more than one");

   // Input is refused only when every stage holds a pixel and the output is stalled.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready))
      else $error("input refused while the pipeline has room");

   // A stalled stage 3 holds its pixel until the output moves.
   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> (v3_ff && $stable(d3_ff) && $stable(op3_ff)))
      else $error("stage 3 contents changed during a stall");

endmodule

@@ bench/pixel_blend_checker.sv @@
// Predicts and checks each composited pixel that the compositor returns.
module pixel_blend_checker
   import spc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          outstanding,
   output int          pixels_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] pixel;
      logic        write_en;
   } pixel_result_type;

   logic [2:0]       mode_reg;
   logic [31:0]      key_reg;
   logic [8:0]       fade_reg;
   pixel_result_type expected_pixels [$];
   int               errs;
   int               seen;

   function automatic logic [7:0] clamp_lane(int unsigned v);
      return (v > 255) ? CHAN_MAX : v[7:0];
   endfunction

   function automatic logic [31:0] weighted_mix(logic [31:0] d, logic [31:0] s,
                                                logic [7:0] w);
      logic [31:0] r;
      int unsigned wi;
      int unsigned acc;
      wi = 32'(w);
      for (int i = 0; i < 3; i++) begin
         acc = d[i*8 +: 8] * (255 - wi) + s[i*8 +: 8] * wi;
         r[i*8 +: 8] = 8'(acc / 255);
      end
      r[31:24] = clamp_lane(wi + d[31:24]);
      return r;
   endfunction

   function automatic logic [31:0] premul_over(logic [31:0] d, logic [31:0] s);
      logic [31:0] r;
      int unsigned c;
      int unsigned sa;
      int unsigned da;
      sa = 32'(s[31:24]);
      da = 32'(d[31:24]);
      if (da == 0 || sa == 255)
         return s;
      if (sa == 0)
         return d;
      c = 255 - sa;
      r[31:24] = clamp_lane(sa + (da * c) / 255);
      for (int i = 0; i < 3; i++)
         r[i*8 +: 8] = clamp_lane((d[i*8 +: 8] * c + s[i*8 +: 8] * 255) / 255);
      return r;
   endfunction

   // Combine rule picked by the current blend mode register.
   function automatic pixel_result_type composite_pixel(logic [31:0] d, logic [31:0] s,
                                                        logic [31:0] m);
      pixel_result_type r;
      int unsigned      f;
      int unsigned      w;
      r.write_en = 1'b1;
      case (mode_reg)
         MODE_MASK:   r.pixel = weighted_mix(d, s, m[23:16]);
         MODE_PREMUL: r.pixel = premul_over(d, s);
         MODE_KEY: begin
            if (s == key_reg) begin
               r.pixel    = d;
               r.write_en = 1'b0;
            end else begin
               r.pixel = s | OPAQUE_ALPHA;
            end
         end
         MODE_FADED: begin
            f = 32'((fade_reg > FADE_ONE) ? FADE_ONE : fade_reg);
            w = (s[31:24] * f) >> 8;
            r.pixel = weighted_mix(d, s, w[7:0]);
         end
         default:     r.pixel = s | OPAQUE_ALPHA;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      pixel_result_type want;
      if (reset) begin
         mode_reg = MODE_OPAQUE;
         key_reg  = '0;
         fade_reg = FADE_ONE;
         expected_pixels.delete();
         errs = 0;
         seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BLEND_MODE:  mode_reg = csr_wdata[2:0];
               CSR_KEY_COLOR:   key_reg  = csr_wdata;
               CSR_FADE_FACTOR: fade_reg = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(composite_pixel(req_tdata[31:0], req_tdata[63:32],
                                                      req_tdata[95:64]));
         if (rsp_tvalid && rsp_tready) begin
            seen++;
            if (expected_pixels.size() == 0) begin
               errs++;
               $display("%0t: unexpected result, expected none, actual %08h we=%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  errs++;
                  $display("%0t: out_pixel mismatch, expected %08h, actual %08h",
                           $time, want.pixel, rsp_tdata);
               end
               if (rsp_tuser !== want.write_en) begin
                  errs++;
                  $display("%0t: write_enable mismatch, expected %b, actual %b",
                           $time, want.write_en, rsp_tuser);
               end
            end
         end
      end
      mismatch_count <= errs;
      outstanding    <= expected_pixels.size();
      pixels_checked <= seen;
   end

endmodule

@@ bench/sprite_pixel_compositor_core_tb.sv @@
// Top of the compositor bench: clock, reset, stimulus, result sink and verdict.
module sprite_pixel_compositor_core_tb
   import spc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Mode codes with no rule of their own; the block treats them as opaque copy.
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;
   // Register index with nothing behind it; writes to it must change nothing.
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   // The pipeline is four stages deep, so a handful of spare cycles covers it.
   localparam int DRAIN_CYCLES    = 16;
   localparam int RANDOM_PHASES   = 16;
   localparam int ITEMS_PER_PHASE = 50;
   // The result side goes quiet for a long stretch after this many transfers.
   localparam int HOLD_AFTER      = 300;
   localparam int HOLD_CYCLES     = 200;
   // Cycles without any transfer before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 3000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_BLEND_MODE;
   logic [31:0] csr_wdata  = '0;

   int mismatch_count;
   int outstanding;
   int pixels_checked;
   int pixels_sent      = 0;
   int settings_applied = 0;
   int idle_cycles      = 0;
   bit sender_steady    = 1'b0;
   logic [31:0] current_key = '0;

   always #1 clock = ~clock;

   sprite_pixel_compositor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pixel_blend_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .pixels_checked (pixels_checked)
   );

   // Offers one pixel triple, after a random gap unless the sender is in a steady
   // stretch, and returns at the edge where the transfer takes place. The valid is
   // left high so that a following pixel with no gap goes out back to back.
   task automatic send_pixel(input logic [31:0] dest, input logic [31:0] src,
                             input logic [31:0] mask);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mask, src, dest};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      // Every 32 pixels the sender decides afresh whether to run without gaps.
      if (pixels_sent % 32 == 0)
         sender_steady = ($urandom_range(0, 3) == 0);
   endtask

   // Stops offering and waits until every predicted result has come back, then
   // lets the pipeline run empty so that a register write cannot hit a pixel.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write, after which the enable is lowered again before the task returns,
   // so that back-to-back writes never raise and lower the enable within the same time step.
   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Rewrites all three registers once the block is idle. The bits above each
   // register's width carry random junk, which the block must discard.
   task automatic apply_setting(input logic [2:0] mode, input logic [31:0] key,
                                input logic [8:0] fade);
      logic [31:0] junk;
      drain_pipeline();
      junk = $urandom();
      write_csr(CSR_BLEND_MODE, {junk[31:3], mode});
      write_csr(CSR_KEY_COLOR, key);
      junk = $urandom();
      write_csr(CSR_FADE_FACTOR, {junk[31:9], fade});
      current_key = key;
      settings_applied++;
   endtask

   // Random pixel whose alpha lands on the early-out values often enough to
   // reach the pass-through branches of the premultiplied rule.
   function automatic logic [31:0] random_pixel();
      logic [31:0] p;
      p = $urandom();
      case ($urandom_range(0, 3))
         0: p[31:24] = 8'h00;
         1: p[31:24] = 8'hFF;
         default: ;
      endcase
      return p;
   endfunction

   // Result sink. Before each transfer it stalls for a random number of cycles,
   // except in steady stretches where it takes every result at once. After a
   // fixed number of transfers it holds off for a long time, while the sender
   // keeps offering, so the pipeline fills completely and blocks its input.
   initial begin : result_sink
      int stall;
      int taken;
      bit sink_steady;
      taken       = 0;
      sink_steady = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AFTER)
            stall = HOLD_CYCLES;
         else if (sink_steady)
            stall = 0;
         else
            stall = $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (taken % 40 == 0)
            sink_steady = ($urandom_range(0, 3) == 0);
      end
   end

   // Watchdog: any cycle with a transfer on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      logic [2:0]  mode_cycle [8];
      logic [2:0]  mode;
      logic [8:0]  fade;
      logic [31:0] dest;
      logic [31:0] src;
      logic [31:0] mask;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values: opaque copy, so both all-zero and
      // all-one pixels come out with alpha forced to full.
      send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Mask blend at zero weight, at full weight, and with alpha saturating.
      apply_setting(MODE_MASK, 32'h0000_0000, FADE_ONE);
      send_pixel(32'h8010_2030, 32'h40F0_E0D0, 32'hFF00_FFFF);
      send_pixel(32'h8010_2030, 32'h40F0_E0D0, 32'h00FF_0000);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 32'h0080_0000);

      // Premultiplied over: transparent destination, opaque sprite, transparent
      // sprite, and a nearly transparent sprite whose channels saturate.
      apply_setting(MODE_PREMUL, 32'h0000_0000, FADE_ONE);
      send_pixel(32'h0011_2233, 32'h8044_5566, 32'h0000_0000);
      send_pixel(32'h8011_2233, 32'hFF44_5566, 32'h0000_0000);
      send_pixel(32'h8011_2233, 32'h0044_5566, 32'h0000_0000);
      send_pixel(32'hFFFF_FFFF, 32'h01FF_FFFF, 32'h0000_0000);

      // Colour key: an exact match suppresses the write, one bit off does not.
      apply_setting(MODE_KEY, 32'h1234_5678, FADE_ONE);
      send_pixel(32'hA5A5_A5A5, 32'h1234_5678, 32'h0000_0000);
      send_pixel(32'hA5A5_A5A5, 32'h1234_5679, 32'h0000_0000);

      // Faded blend at full fade, at zero, and above one where it saturates.
      apply_setting(MODE_FADED, 32'h1234_5678, FADE_ONE);
      send_pixel(32'h4020_4060, 32'hFFC0_A080, 32'h0000_0000);
      apply_setting(MODE_FADED, 32'h1234_5678, 9'd0);
      send_pixel(32'h4020_4060, 32'hFFC0_A080, 32'h0000_0000);
      apply_setting(MODE_FADED, 32'h1234_5678, 9'h1FF);
      send_pixel(32'h4020_4060, 32'h80C0_A080, 32'h0000_0000);

      // The three unused mode codes must all behave as opaque copy.
      apply_setting(MODE_SPARE_A, 32'h0000_0000, FADE_ONE);
      send_pixel(32'h1111_1111, 32'h0022_3344, 32'h0000_0000);
      apply_setting(MODE_SPARE_B, 32'h0000_0000, FADE_ONE);
      send_pixel(32'h1111_1111, 32'h0022_3344, 32'h0000_0000);
      apply_setting(MODE_SPARE_C, 32'h0022_3344, FADE_ONE);
      send_pixel(32'h1111_1111, 32'h0055_6677, 32'h0000_0000);

      // A write to the unused index must leave the mode alone, so a sprite that
      // equals the key written above is still copied rather than skipped.
      drain_pipeline();
      write_csr(CSR_SPARE, {29'd0, MODE_KEY});
      send_pixel(32'h1111_1111, 32'h0022_3344, 32'h0000_0000);

      // Random phases: each one rewrites every register and then streams pixels.
      mode_cycle = '{MODE_OPAQUE, MODE_MASK, MODE_PREMUL, MODE_KEY, MODE_FADED,
                     MODE_SPARE_A, MODE_SPARE_B, MODE_SPARE_C};
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = mode_cycle[phase % 8];
         case ($urandom_range(0, 4))
            0: fade = 9'd0;
            1: fade = FADE_ONE;
            2: fade = 9'h1FF;
            default: fade = 9'($urandom_range(0, 511));
         endcase
         apply_setting(mode, $urandom(), fade);
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_SPARE, $urandom());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            dest = random_pixel();
            src  = random_pixel();
            mask = $urandom();
            case ($urandom_range(0, 3))
               0: mask[23:16] = 8'h00;
               1: mask[23:16] = 8'hFF;
               default: ;
            endcase
            // Key hits are common enough to matter in every mode, not only keying.
            if ($urandom_range(0, 3) == 0)
               src = current_key;
            send_pixel(dest, src, mask);
         end
      end

      drain_pipeline();

      $display("Checked %0d of %0d pixels over %0d register settings: every mode code,",
               pixels_checked, pixels_sent, settings_applied);
      $display("key hits, fade extremes, junk in unused bits and a long result stall.");
      if (mismatch_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
